// File: design/ledscan_pkg.sv
// ----------------------------------------------------------------------------
// ledscan_pkg
// Shared types and constants of the LED matrix row scanner.
// ----------------------------------------------------------------------------
package ledscan_pkg;

    localparam int ROW_MAX    = 16;
    localparam int COL_MAX    = 16;
    localparam int DRIVE_W    = 5;
    localparam int BITS_W     = 5;
    localparam int COLUMN_W   = 3;
    localparam int SAMPLE_W   = 12;
    localparam int DARK_W     = 16;
    localparam int ON_W       = 20;
    localparam int ON_US_W    = 10;
    localparam int ON_FRAC_W  = 10;
    localparam int VOFF_W     = 11;
    localparam int SLEW_SHIFT = 9;
    localparam int STEP_W     = ON_W + 1 - SLEW_SHIFT;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DARK_W-1:0] LEVEL_MIN = 16'd10;
    localparam logic [DARK_W-1:0] LEVEL_MAX = 16'd2000;
    localparam logic [ON_W-1:0]   ON_MIN    = 20'd10240;
    localparam logic [ON_W-1:0]   ON_MAX    = 20'd1023150;
    localparam logic [9:0]        ON_STEP   = 10'd509;

    localparam logic [1:0] KIND_IMAGE   = 2'd0;
    localparam logic [1:0] KIND_LIGHT   = 2'd1;
    localparam logic [1:0] KIND_REFRESH = 2'd2;
    localparam logic [1:0] KIND_DARK    = 2'd3;

    typedef enum logic [1:0] {
        OP_IMAGE,
        OP_LIGHT,
        OP_REFRESH,
        OP_DARK
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [COLUMN_W-1:0]   column;
        logic [ROW_MAX-1:0]    row_bits;
        logic [SAMPLE_W-1:0]   sample;
        logic [DARK_W-1:0]     dark_value;
    } cmd_t;

endpackage

// File: design/ledscan_item_if.sv
// ----------------------------------------------------------------------------
// ledscan_item_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface ledscan_item_if;

    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  column;
    logic [4:0]  column_bits;
    logic [11:0] light_sample;
    logic [15:0] dark_level_value;

    modport source
    (
        output valid, kind, column, column_bits, light_sample, dark_level_value,
        input  ready
    );

    modport sink
    (
        input  valid, kind, column, column_bits, light_sample, dark_level_value,
        output ready
    );

endinterface

// File: design/ledscan_result_if.sv
// ----------------------------------------------------------------------------
// ledscan_result_if
// Result item channel: valid/ready handshake with the drive fields.
// ----------------------------------------------------------------------------
interface ledscan_result_if;

    logic       valid;
    logic       ready;
    logic [4:0] row_drive;
    logic [4:0] col_drive;
    logic [9:0] on_time_us;
    logic       last;

    modport source
    (
        output valid, row_drive, col_drive, on_time_us, last,
        input  ready
    );

    modport sink
    (
        input  valid, row_drive, col_drive, on_time_us, last,
        output ready
    );

endinterface

// File: design/ledscan_front.sv
// ----------------------------------------------------------------------------
// ledscan_front
// Accepts input items, decodes the kind into a command, reorders the column
// bits into row order and drops image writes to columns out of range.
// ----------------------------------------------------------------------------
module ledscan_front #(
    parameter int ROWS = 5,
    parameter int COLS = 5
)(
    input  logic                clk,
    input  logic                rst_n,
    ledscan_item_if.sink        item,
    output logic                cmd_valid,
    output ledscan_pkg::cmd_t   cmd,
    input  logic                cmd_ready
);

    import ledscan_pkg::*;

    logic cmd_valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic keep;
    logic take;

    assign item.ready = !cmd_valid_reg || cmd_ready;
    assign take       = item.valid && item.ready;
    assign cmd_valid  = cmd_valid_reg;
    assign cmd        = cmd_reg;

    always_comb
    begin
        cmd_next            = '0;
        cmd_next.column     = item.column;
        cmd_next.sample     = item.light_sample;
        cmd_next.dark_value = item.dark_level_value;
        for (int i = 0; i < ROW_MAX; i++)
        begin
            if (i < ROWS && (ROWS - 1 - i) < BITS_W)
            begin
                cmd_next.row_bits[i] = item.column_bits[3'(ROWS - 1 - i)];
            end
        end
        keep = 1'b1;
        case (item.kind)
            KIND_IMAGE:
            begin
                cmd_next.op = OP_IMAGE;
                keep        = (int'(item.column) < COLS);
            end
            KIND_LIGHT:   cmd_next.op = OP_LIGHT;
            KIND_REFRESH: cmd_next.op = OP_REFRESH;
            KIND_DARK:    cmd_next.op = OP_DARK;
            default:      cmd_next.op = OP_REFRESH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            cmd_valid_reg <= keep;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: design/ledscan_queue.sv
// ----------------------------------------------------------------------------
// ledscan_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ledscan_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  ledscan_pkg::cmd_t   push_cmd,
    output logic                push_ready,
    output logic                pop_valid,
    output ledscan_pkg::cmd_t   pop_cmd,
    input  logic                pop_ready
);

    import ledscan_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/ledscan_back.sv
// ----------------------------------------------------------------------------
// ledscan_back
// Executes commands: image store writes, dark level and target updates,
// on-time slewing and the row scan that emits drive items.
// ----------------------------------------------------------------------------
module ledscan_back #(
    parameter int ROWS = 5,
    parameter int COLS = 5
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  ledscan_pkg::cmd_t   cmd,
    output logic                cmd_ready,
    ledscan_result_if.source    result
);

    import ledscan_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROWS-1:0] ROW_ALL = '1;
    localparam logic [ROW_MAX-1:0] ROW_ALL_WIDE = ROW_MAX'(ROW_ALL);
    localparam logic [DRIVE_W-1:0] ROW_OFF = ROW_ALL_WIDE[DRIVE_W-1:0];

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_TARGET = 5'b00010,
        ST_SLEW   = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_LAST   = 5'b10000
    } state_t;

    state_t                state_reg;
    logic [ROWS-1:0]       store_reg [COLS];
    logic [DARK_W-1:0]     dark_reg;
    logic [ON_W-1:0]       target_reg;
    logic [ON_W-1:0]       current_reg;
    logic [VOFF_W-1:0]     voff_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [ON_W:0]         diff_reg;
    logic [RW-1:0]         row_reg;

    logic                  out_valid_reg;
    logic [DRIVE_W-1:0]    row_drive_reg;
    logic [DRIVE_W-1:0]    col_drive_reg;
    logic [ON_US_W-1:0]    on_time_reg;
    logic                  last_reg;

    logic                  pop;
    logic                  slot_free;
    logic                  emit;
    logic [DARK_W-1:0]     sample_wide;
    logic [DARK_W-1:0]     dark_next;
    logic [DARK_W-1:0]     level;
    logic [VOFF_W-1:0]     voff_next;
    logic [ON_W:0]         sum;
    logic [STEP_W-1:0]     step_next;
    logic [ON_W:0]         step_wide;
    logic [COLS-1:0]       col_set;
    logic [COL_MAX-1:0]    col_wide;
    logic [ROWS-1:0]       row_sel;
    logic [ROW_MAX-1:0]    row_wide;

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign pop        = cmd_valid && cmd_ready;
    assign slot_free  = !out_valid_reg || result.ready;
    assign emit       = slot_free && ((state_reg == ST_SCAN && col_set != '0) ||
                                      state_reg == ST_LAST);

    assign result.valid      = out_valid_reg;
    assign result.row_drive  = row_drive_reg;
    assign result.col_drive  = col_drive_reg;
    assign result.on_time_us = on_time_reg;
    assign result.last       = last_reg;

    always_comb
    begin
        sample_wide = DARK_W'(cmd.sample);
        dark_next   = (sample_wide > dark_reg) ? sample_wide : dark_reg;
        level       = dark_next - sample_wide;
        if (level > LEVEL_MAX)
        begin
            voff_next = VOFF_W'(LEVEL_MAX - LEVEL_MIN);
        end
        else if (level < LEVEL_MIN)
        begin
            voff_next = '0;
        end
        else
        begin
            voff_next = VOFF_W'(level - LEVEL_MIN);
        end
        sum       = (ON_W + 1)'(current_reg) + (ON_W + 1)'(target_reg);
        step_next = sum[ON_W:SLEW_SHIFT];
        if (step_next == '0)
        begin
            step_next = STEP_W'(1);
        end
        step_wide = (ON_W + 1)'(step_reg);
        for (int j = 0; j < COLS; j++)
        begin
            col_set[j] = store_reg[j][row_reg];
        end
        col_wide = COL_MAX'(col_set);
        row_sel  = ROW_ALL & ~(ROWS'(1) << row_reg);
        row_wide = ROW_MAX'(row_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dark_reg      <= '0;
            target_reg    <= ON_MIN;
            current_reg   <= ON_MIN;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < COLS; j++)
            begin
                store_reg[j] <= '0;
            end
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        case (cmd.op)
                            OP_IMAGE:
                            begin
                                for (int j = 0; j < COLS; j++)
                                begin
                                    if (int'(cmd.column) == j)
                                    begin
                                        store_reg[j] <= cmd.row_bits[ROWS-1:0];
                                    end
                                end
                            end
                            OP_LIGHT:
                            begin
                                dark_reg  <= dark_next;
                                state_reg <= ST_TARGET;
                            end
                            OP_DARK:
                            begin
                                dark_reg <= cmd.dark_value;
                            end
                            OP_REFRESH:
                            begin
                                state_reg <= ST_SLEW;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_TARGET:
                begin
                    target_reg <= ON_MIN + ON_W'(voff_reg * ON_STEP);
                    state_reg  <= ST_IDLE;
                end
                ST_SLEW:
                begin
                    if ($signed(diff_reg) > $signed(step_wide))
                    begin
                        current_reg <= current_reg + ON_W'(step_reg);
                    end
                    else if ($signed(diff_reg) < -$signed(step_wide))
                    begin
                        current_reg <= current_reg - ON_W'(step_reg);
                    end
                    else
                    begin
                        current_reg <= target_reg;
                    end
                    row_reg   <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (col_set == '0 || slot_free)
                    begin
                        if (row_reg == RW'(ROWS - 1))
                        begin
                            state_reg <= ST_LAST;
                        end
                        else
                        begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                end
                ST_LAST:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && cmd.op == OP_LIGHT)
        begin
            voff_reg <= voff_next;
        end
        if (pop && cmd.op == OP_REFRESH)
        begin
            step_reg <= step_next;
            diff_reg <= (ON_W + 1)'(target_reg) - (ON_W + 1)'(current_reg);
        end
        if (state_reg == ST_SCAN && col_set != '0 && slot_free)
        begin
            row_drive_reg <= row_wide[DRIVE_W-1:0];
            col_drive_reg <= col_wide[DRIVE_W-1:0];
            on_time_reg   <= current_reg[ON_FRAC_W +: ON_US_W];
            last_reg      <= 1'b0;
        end
        else if (state_reg == ST_LAST && slot_free)
        begin
            row_drive_reg <= ROW_OFF;
            col_drive_reg <= '0;
            on_time_reg   <= '0;
            last_reg      <= 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> col_drive_reg == '0 && row_drive_reg == ROW_OFF)
        else $error("all-off item carries lit columns");

    assert property (@(posedge clk) disable iff (!rst_n)
        current_reg >= ON_MIN && current_reg <= ON_MAX)
        else $error("current on-time out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        target_reg >= ON_MIN && target_reg <= ON_MAX)
        else $error("target on-time out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(current_reg) |-> $past(state_reg == ST_SLEW))
        else $error("on-time changed outside slew step");

endmodule

// File: design/led_matrix_row_scanner_core.sv
// An accepted item passes the front command register and the queue, then
// the back end; image and dark level items finish in its idle state, light
// samples also pass its target state. Refresh: slew, the row scan and the
// all-off item; a full result register stalls the scan on a lit row.
// Reset: asynchronous; clears image store, dark level; on-times to ON_MIN.
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_core
// Row-multiplexed LED matrix driver with ambient-light brightness control.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_core #(
    parameter int ROWS = 5,
    parameter int COLS = 5
)(
    input  logic               clk,
    input  logic               rst_n,
    ledscan_item_if.sink       item,
    ledscan_result_if.source   result
);

    import ledscan_pkg::*;

    logic front_valid;
    cmd_t front_cmd;
    logic front_ready;
    logic back_valid;
    cmd_t back_cmd;
    logic back_ready;

    ledscan_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    ledscan_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_cmd   (front_cmd),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_cmd    (back_cmd),
        .pop_ready  (back_ready)
    );

    ledscan_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_ready (back_ready),
        .result    (result)
    );

endmodule
